@@ src/bcfp_pkg.sv @@
// shared types and character constants for the bracket command frame parser
package bcfp_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] ARG_LOW  = 8'd32;
  localparam logic [7:0] ARG_HIGH = 8'd127;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_ERROR = 3'd1,
    EV_Q     = 3'd2,
    EV_S     = 3'd3,
    EV_R     = 3'd4,
    EV_E     = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    CMD_Q = 2'd0,
    CMD_S = 2'd1,
    CMD_R = 2'd2,
    CMD_E = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_CMD   = 3'b010,
    PH_ARGS  = 3'b100
  } phase_t;

  // classified request handed from front to back
  typedef struct packed {
    logic   clear;
    event_t ev;
  } action_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

@@ src/bcfp_front.sv @@
// front end: accepts requests and runs the frame parser
module bcfp_front
  import bcfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          mode,
  input  logic [7:0]    byte_value,
  input  queue_status_t qs,
  output logic          push,
  output action_t       push_data
);

  phase_t phase, phase_next;
  cmd_t   held, held_next;
  event_t ev;

  assign in_stall = qs.full;
  assign push     = in_valid && !qs.full;

  always_comb begin
    phase_next = phase;
    held_next  = held;
    ev         = EV_NONE;
    unique case (phase)
      PH_CMD: begin
        priority if (byte_value == CH_OPEN) begin
          ev = EV_ERROR;
        end else if (byte_value == CH_Q) begin
          held_next = CMD_Q; phase_next = PH_ARGS;
        end else if (byte_value == CH_S) begin
          held_next = CMD_S; phase_next = PH_ARGS;
        end else if (byte_value == CH_R) begin
          held_next = CMD_R; phase_next = PH_ARGS;
        end else if (byte_value == CH_E) begin
          held_next = CMD_E; phase_next = PH_ARGS;
        end else begin
          ev = EV_ERROR; phase_next = PH_START;
        end
      end
      PH_ARGS: begin
        priority if (byte_value == CH_CLOSE) begin
          phase_next = PH_START;
          unique case (held)
            CMD_Q: ev = EV_Q;
            CMD_S: ev = EV_S;
            CMD_R: ev = EV_R;
            CMD_E: ev = EV_E;
            default: ev = EV_Q;
          endcase
        end else if (byte_value == CH_OPEN) begin
          ev = EV_ERROR; phase_next = PH_START;
        end else if (byte_value >= ARG_LOW && byte_value <= ARG_HIGH) begin
          ev = EV_NONE;
        end else begin
          ev = EV_ERROR; phase_next = PH_START;
        end
      end
      default: begin
        // start phase, also catches any stray code
        if (byte_value == CH_OPEN) begin
          phase_next = PH_CMD;
        end else begin
          ev = EV_ERROR; phase_next = PH_START;
        end
      end
    endcase
    // a clear request leaves the parser untouched
    if (mode) begin
      phase_next = phase;
      held_next  = held;
      ev         = EV_NONE;
    end
  end

  assign push_data.clear = mode;
  assign push_data.ev    = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      held  <= CMD_Q;
    end else if (push) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

@@ src/bcfp_queue.sv @@
// short queue between the parser and the counter stage
module bcfp_queue
  import bcfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  action_t       push_data,
  input  logic          pop,
  output action_t       pop_data,
  output queue_status_t qs
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  action_t         entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;

  assign qs.valid = (count != '0);
  assign qs.full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/bcfp_back.sv @@
// back end: frame counters and the registered result
module bcfp_back
  import bcfp_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  action_t     act,
  input  logic        act_valid,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_code,
  output logic [31:0] q_count,
  output logic [31:0] s_count,
  output logic [31:0] r_count,
  output logic [31:0] e_count,
  output logic [31:0] error_count
);

  logic [COUNT_WIDTH-1:0] q_total, s_total, r_total, e_total, err_total;
  logic [COUNT_WIDTH-1:0] q_next, s_next, r_next, e_next, err_next;

  assign pop = act_valid && (!out_valid || !out_stall);

  always_comb begin
    q_next   = q_total;
    s_next   = s_total;
    r_next   = r_total;
    e_next   = e_total;
    err_next = err_total;
    if (act.clear) begin
      q_next   = '0;
      s_next   = '0;
      r_next   = '0;
      e_next   = '0;
      err_next = '0;
    end else begin
      unique case (act.ev)
        EV_ERROR: err_next = err_total + COUNT_WIDTH'(1);
        EV_Q:     q_next   = q_total + COUNT_WIDTH'(1);
        EV_S:     s_next   = s_total + COUNT_WIDTH'(1);
        EV_R:     r_next   = r_total + COUNT_WIDTH'(1);
        EV_E:     e_next   = e_total + COUNT_WIDTH'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_total   <= '0;
      s_total   <= '0;
      r_total   <= '0;
      e_total   <= '0;
      err_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        q_total   <= q_next;
        s_total   <= s_next;
        r_total   <= r_next;
        e_total   <= e_next;
        err_total <= err_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, low 32 bits of each counter
  always_ff @(posedge clk) begin
    if (pop) begin
      event_code  <= act.ev;
      q_count     <= 32'(q_next);
      s_count     <= 32'(s_next);
      r_count     <= 32'(r_next);
      e_count     <= 32'(e_next);
      error_count <= 32'(err_next);
    end
  end

endmodule

@@ src/bracket_command_frame_parser_top.sv @@
// top level of the bracket command frame parser with frame counters
//
//   channel  valid      stall      payload
//   input    in_valid   in_stall   mode, byte_value
//   output   out_valid  out_stall  event_code, q/s/r/e_count, error_count
//
// one request per cycle while in_stall is low; a request is written into the queue at
// acceptance, and its result is then registered in the counter stage's output register
// the two-entry queue lets the parser keep taking bytes while a result is stalled
// in_stall rises only when the queue is full
// synchronous reset returns the parser to the start phase and zeroes all counters
module bracket_command_frame_parser_top
  import bcfp_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_code,
  output logic [31:0] q_count,
  output logic [31:0] s_count,
  output logic [31:0] r_count,
  output logic [31:0] e_count,
  output logic [31:0] error_count
);

  queue_status_t qs;
  logic          push, pop;
  action_t       push_data, pop_data;

  bcfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .byte_value (byte_value),
    .qs         (qs),
    .push       (push),
    .push_data  (push_data)
  );

  bcfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qs        (qs)
  );

  bcfp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .act         (pop_data),
    .act_valid   (qs.valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_code  (event_code),
    .q_count     (q_count),
    .s_count     (s_count),
    .r_count     (r_count),
    .e_count     (e_count),
    .error_count (error_count)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qs.full)
    else $error("queue written while full");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> qs.valid)
    else $error("counter stage took from an empty queue");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_error_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 (out_valid && event_code == EV_ERROR)
      |-> error_count != $past(error_count))
    else $error("error result without a change of the error count");

endmodule
